>>> design/assert_macros.svh
// Assertion macros for the RTL of the message frame parser.
// Depends on nothing; included by rpc_message_frame_parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("rmfp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("rmfp assertion failed");

`endif

>>> design/rmfp_pkg.sv
// Package of the message frame parser: payload types, phase and status codes,
// signature letter codes and a byte lane helper. Depends on nothing.
package rmfp_pkg;

	localparam int SIG_DEPTH_DEF = 32;

	// Parse phases; a byte's field kind is the phase that consumes it, except in PH_ARG (kind 8 to 10 by letter).
	localparam logic [3:0] PH_LEN     = 4'd0;
	localparam logic [3:0] PH_TYPE    = 4'd1;
	localparam logic [3:0] PH_SERIAL  = 4'd2;
	localparam logic [3:0] PH_TOKEN   = 4'd3;
	localparam logic [3:0] PH_FROM    = 4'd4;
	localparam logic [3:0] PH_TO      = 4'd5;
	localparam logic [3:0] PH_FUNC    = 4'd6;
	localparam logic [3:0] PH_SIG     = 4'd7;
	localparam logic [3:0] PH_ARG     = 4'd8;
	localparam logic [3:0] PH_TRAIL   = 4'd11;
	localparam logic [3:0] PH_DISCARD = 4'd12;

	localparam logic [2:0] ST_PENDING   = 3'd0;
	localparam logic [2:0] ST_ACCEPT    = 3'd1;
	localparam logic [2:0] ST_TRUNC     = 3'd2;
	localparam logic [2:0] ST_BADLETTER = 3'd3;
	localparam logic [2:0] ST_NOTIS     = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	// Signature letter codes as kept in the signature memory.
	localparam logic [1:0] SC_INT    = 2'd0;
	localparam logic [1:0] SC_DOUBLE = 2'd1;
	localparam logic [1:0] SC_STRING = 2'd2;
	localparam logic [1:0] SC_OTHER  = 2'd3;

	// Progress of the "is" signature check.
	localparam logic [1:0] IS_EMPTY = 2'd0;
	localparam logic [1:0] IS_I     = 2'd1;
	localparam logic [1:0] IS_IS    = 2'd2;
	localparam logic [1:0] IS_OTHER = 2'd3;

	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_S = 8'h73;

	typedef struct packed {
		logic [7:0] data_byte;
	} rmfp_byte_t;

	typedef struct packed {
		logic [31:0] error_type_code;
	} rmfp_cfg_t;

	typedef struct packed {
		logic [3:0] field_kind;
		logic [7:0] byte_value;
		logic       field_end;
		logic [4:0] arg_number;
		logic       message_done;
		logic [2:0] status;
	} rmfp_result_t;

	// Places a byte into lane sel of a little-endian 32-bit word.
	function automatic logic [31:0] rmfp_lane(input logic [7:0] b, input logic [1:0] sel);
		return {24'd0, b} << {sel, 3'b000};
	endfunction

endpackage

>>> design/rmfp_stream_if.sv
// Valid/ready channel interface used by every port of the message frame parser.
// Depends on nothing; the payload type is given at instantiation.
interface rmfp_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> design/rpc_message_frame_parser.sv
// Message frame parser: tags every byte of a message stream with its field.
// Depends on rmfp_pkg, rmfp_stream_if and assert_macros.svh.
//
// Usage:
// in_bytes carries one message byte per transaction, results carries one result
// per input byte, and cfg carries a write of the error type code register. All
// three channels use valid/ready; a transaction completes at a rising clk edge
// where both are high. cfg is always ready and should only be written while no
// byte is in flight.
// A byte accepted at a rising edge is on results from that edge on. Throughput
// is one byte per cycle while results does not stall. All parsing of a byte is
// done by the logic between the parser state registers and the result register;
// the registered read port of the signature memory is fed the next argument
// pointer, so the current argument's letter code is ready when its bytes arrive.
// When results stalls, the held result stays put and in_bytes.ready drops, so
// no byte is lost; ready returns in the cycle the result is taken.
// arst_n clears the parser to expect a length field, clears the register to
// zero and empties the result register. The signature memory is not cleared;
// only entries written earlier in the same message are ever used.
module rpc_message_frame_parser
	import rmfp_pkg::*;
#(
	parameter int SIG_DEPTH = SIG_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rmfp_stream_if.sink   in_bytes,
	rmfp_stream_if.source results,
	rmfp_stream_if.sink   cfg
);

`include "assert_macros.svh"

	localparam int PW = $clog2(SIG_DEPTH + 1);
	localparam int AW = $clog2(SIG_DEPTH);
	localparam logic [PW-1:0] DEPTH_P = PW'(SIG_DEPTH);

	// Parser state.
	logic [3:0]    phase_q, phase_d;
	logic [2:0]    biw_q, biw_d;
	logic [31:0]   rem_q, rem_d;
	logic [31:0]   mtype_q, mtype_d;
	logic [PW-1:0] sig_len_q, sig_len_d;
	logic [PW-1:0] arg_ptr_q, arg_ptr_d;
	logic [2:0]    ferr_q, ferr_d;
	logic [1:0]    isis_q, isis_d;
	// The first unknown letter of the signature; reaching its argument fails.
	logic          bad_seen_q, bad_seen_d;
	logic [PW-1:0] bad_idx_q, bad_idx_d;

	logic [31:0]   err_code_q;

	// Signature letter memory and its registered read port.
	logic [1:0]    sig_mem [SIG_DEPTH];
	logic [1:0]    code_q;
	logic          sig_we;
	logic [1:0]    sig_wcode;
	logic [PW-1:0] rd_ptr;

	logic          ovalid_q;
	rmfp_result_t  out_q;
	rmfp_result_t  res;

	logic          in_acc;
	logic [7:0]    b;
	logic [3:0]    biw_inc;
	logic [31:0]   acc;
	logic [31:0]   rem_dec;
	logic [1:0]    code_eff;
	logic          do_next;

	assign b       = in_bytes.data.data_byte;
	assign in_acc  = in_bytes.valid && in_bytes.ready;
	assign biw_inc = {1'b0, biw_q} + 4'd1;
	assign rem_dec = rem_q - 32'd1;

	// The result register frees up when its content is taken, so a byte can be
	// accepted in the same cycle a stalled result leaves.
	assign in_bytes.ready = !ovalid_q || results.ready;
	assign results.valid  = ovalid_q;
	assign results.data   = out_q;
	assign cfg.ready      = 1'b1;

	always_comb begin
		phase_d    = phase_q;
		biw_d      = biw_q;
		rem_d      = rem_q;
		mtype_d    = mtype_q;
		sig_len_d  = sig_len_q;
		arg_ptr_d  = arg_ptr_q;
		ferr_d     = ferr_q;
		isis_d     = isis_q;
		bad_seen_d = bad_seen_q;
		bad_idx_d  = bad_idx_q;
		sig_we     = 1'b0;
		sig_wcode  = SC_OTHER;
		do_next    = 1'b0;
		acc        = 32'd0;
		code_eff   = SC_OTHER;

		res.field_kind   = PH_LEN;
		res.byte_value   = b;
		res.field_end    = 1'b0;
		res.arg_number   = 5'd0;
		res.message_done = 1'b0;
		res.status       = ST_PENDING;

		if (phase_q == PH_LEN) begin
			// The first length byte opens a new message.
			if (biw_q == 3'd0) begin
				mtype_d    = 32'd0;
				sig_len_d  = '0;
				arg_ptr_d  = '0;
				ferr_d     = ST_PENDING;
				isis_d     = IS_EMPTY;
				bad_seen_d = 1'b0;
			end
			acc = ((biw_q == 3'd0) ? 32'd0 : rem_q) | rmfp_lane(b, biw_q[1:0]);
			if (biw_inc >= 4'd4) begin
				res.field_end = 1'b1;
				biw_d         = 3'd0;
				if (acc <= 32'd4) begin
					res.message_done = 1'b1;
					res.status       = ST_TRUNC;
					rem_d            = 32'd0;
				end else begin
					rem_d   = acc - 32'd4;
					phase_d = PH_TYPE;
				end
			end else begin
				rem_d = acc;
				biw_d = biw_inc[2:0];
			end
		end else begin
			rem_d          = rem_dec;
			res.field_kind = phase_q;
			unique case (phase_q)
				PH_TYPE, PH_SERIAL: begin
					if (phase_q == PH_TYPE) begin
						mtype_d = mtype_q | rmfp_lane(b, biw_q[1:0]);
					end
					biw_d = biw_inc[2:0];
					if (biw_inc >= 4'd4) begin
						res.field_end = 1'b1;
						biw_d         = 3'd0;
						phase_d       = phase_q + 4'd1;
					end
				end
				PH_TOKEN, PH_FROM, PH_TO, PH_FUNC: begin
					if (b == 8'd0) begin
						res.field_end = 1'b1;
						phase_d       = phase_q + 4'd1;
					end
				end
				PH_SIG: begin
					if (b == 8'd0) begin
						res.field_end = 1'b1;
						arg_ptr_d     = '0;
						do_next       = 1'b1;
					end else if (sig_len_q >= DEPTH_P) begin
						ferr_d  = ST_OVERFLOW;
						phase_d = PH_DISCARD;
					end else begin
						priority if (b == CH_I) sig_wcode = SC_INT;
						else if (b == CH_D)     sig_wcode = SC_DOUBLE;
						else if (b == CH_S)     sig_wcode = SC_STRING;
						else                    sig_wcode = SC_OTHER;
						sig_we    = 1'b1;
						sig_len_d = sig_len_q + PW'(1);
						if (sig_wcode == SC_OTHER && !bad_seen_q) begin
							bad_seen_d = 1'b1;
							bad_idx_d  = sig_len_q;
						end
						priority if (isis_q == IS_EMPTY && b == CH_I) isis_d = IS_I;
						else if (isis_q == IS_I && b == CH_S)         isis_d = IS_IS;
						else                                          isis_d = IS_OTHER;
					end
				end
				PH_ARG: begin
					if (arg_ptr_q < sig_len_q && arg_ptr_q < DEPTH_P) begin
						code_eff = code_q;
					end
					res.field_kind = PH_ARG +
						((code_eff == SC_OTHER) ? 4'd2 : {2'b00, code_eff});
					res.arg_number = 5'(arg_ptr_q);
					if (code_eff == SC_INT || code_eff == SC_DOUBLE) begin
						biw_d         = biw_inc[2:0];
						res.field_end = biw_inc >= ((code_eff == SC_INT) ? 4'd4 : 4'd8);
					end else begin
						res.field_end = (b == 8'd0);
					end
					if (res.field_end) begin
						arg_ptr_d = arg_ptr_q + PW'(1);
						do_next   = 1'b1;
					end
				end
				PH_TRAIL, PH_DISCARD: begin
				end
				default: begin
					res.field_kind = PH_DISCARD;
					phase_d        = PH_DISCARD;
				end
			endcase

			// Move on to the next argument, or finish the argument list. The
			// pointer walks the signature in order, so the first unknown letter
			// is the one it meets.
			if (do_next) begin
				priority if (arg_ptr_d >= sig_len_q) begin
					if (mtype_q == err_code_q && isis_q != IS_IS) begin
						ferr_d  = ST_NOTIS;
						phase_d = PH_DISCARD;
					end else begin
						phase_d = PH_TRAIL;
					end
				end else if (bad_seen_q && arg_ptr_d == bad_idx_q) begin
					ferr_d  = ST_BADLETTER;
					phase_d = PH_DISCARD;
				end else begin
					phase_d = PH_ARG;
					biw_d   = 3'd0;
				end
			end

			if (rem_dec == 32'd0) begin
				res.message_done = 1'b1;
				if (ferr_d != ST_PENDING) begin
					res.status = ferr_d;
				end else begin
					res.status = (phase_d == PH_TRAIL) ? ST_ACCEPT : ST_TRUNC;
				end
				phase_d = PH_LEN;
				biw_d   = 3'd0;
			end
		end
	end

	assign rd_ptr = in_acc ? arg_ptr_d : arg_ptr_q;

	// Signature memory: written while the signature is read, read every cycle
	// at the pointer that the next byte will use.
	always_ff @(posedge clk) begin
		if (in_acc && sig_we) begin
			sig_mem[sig_len_q[AW-1:0]] <= sig_wcode;
		end
		code_q <= sig_mem[rd_ptr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEN;
			biw_q      <= 3'd0;
			rem_q      <= 32'd0;
			mtype_q    <= 32'd0;
			sig_len_q  <= '0;
			arg_ptr_q  <= '0;
			ferr_q     <= ST_PENDING;
			isis_q     <= IS_EMPTY;
			bad_seen_q <= 1'b0;
			bad_idx_q  <= '0;
			err_code_q <= 32'd0;
			ovalid_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				err_code_q <= cfg.data.error_type_code;
			end
			if (in_acc) begin
				phase_q    <= phase_d;
				biw_q      <= biw_d;
				rem_q      <= rem_d;
				mtype_q    <= mtype_d;
				sig_len_q  <= sig_len_d;
				arg_ptr_q  <= arg_ptr_d;
				ferr_q     <= ferr_d;
				isis_q     <= isis_d;
				bad_seen_q <= bad_seen_d;
				bad_idx_q  <= bad_idx_d;
				ovalid_q   <= 1'b1;
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_q <= res;
		end
	end

	`RMFP_ASSERT_IMP(a_stall_blocks_input, clk, arst_n,
		ovalid_q && !results.ready, !in_bytes.ready)
	`RMFP_ASSERT_IMP(a_ptr_within_sig, clk, arst_n,
		1'b1, arg_ptr_q <= sig_len_q && sig_len_q <= DEPTH_P)
	`RMFP_ASSERT_NXT(a_done_restarts, clk, arst_n,
		in_acc && res.message_done, phase_q == PH_LEN && biw_q == 3'd0)
	`RMFP_ASSERT_IMP(a_status_only_at_end, clk, arst_n,
		ovalid_q && !out_q.message_done, out_q.status == ST_PENDING)
	`RMFP_ASSERT_IMP(a_arg_phase_has_letter, clk, arst_n,
		phase_q == PH_ARG, arg_ptr_q < sig_len_q)

endmodule
